// ----- hdl/clnws_pkg.sv -----
`timescale 1ns / 1ps

package clnws_pkg;

	typedef enum logic [1:0] {
		MODE_CMD    = 2'd0,
		MODE_DATA   = 2'd1,
		MODE_CURSOR = 2'd2,
		MODE_DIGIT  = 2'd3
	} mode_t;

	// one request as held in the input register
	typedef struct packed {
		mode_t      mode;
		logic [7:0] value;
		logic       row;
		logic [5:0] column;
		logic [3:0] digit;
	} req_t;

	// one strobe on the LCD bus
	typedef struct packed {
		logic       rs;
		logic [3:0] nibble;
		logic       last;
		logic       error;
	} beat_t;

	localparam logic [3:0]  BYTE_LAST = 4'd1;   // final beat of a single-byte request
	localparam logic [3:0]  DIGIT_LAST = 4'd11; // final beat of a big digit
	localparam logic [3:0]  DIGIT_MAX = 4'd9;
	localparam logic [1:0]  ADDR_ROW0 = 2'b10;  // upper bits of 0x80
	localparam logic [1:0]  ADDR_ROW1 = 2'b11;  // upper bits of 0xC0

	// Big digit glyph codes: slots 0,1 on the top line, slots 2,3 on the bottom line.
	function automatic logic [7:0] glyph_code(input logic [3:0] d, input logic [1:0] slot);
		logic [31:0] row_codes;
		begin
			case (d)
				4'd0:    row_codes = 32'h01_02_4C_00;
				4'd1:    row_codes = 32'h20_7C_20_7C;
				4'd2:    row_codes = 32'h04_05_4C_5F;
				4'd3:    row_codes = 32'h06_05_5F_00;
				4'd4:    row_codes = 32'h4C_00_20_03;
				4'd5:    row_codes = 32'h07_04_5F_00;
				4'd6:    row_codes = 32'h07_04_4C_00;
				4'd7:    row_codes = 32'h06_02_20_03;
				4'd8:    row_codes = 32'h07_05_4C_00;
				4'd9:    row_codes = 32'h07_05_20_03;
				default: row_codes = 32'h00_00_00_00;
			endcase
			case (slot)
				2'd0:    glyph_code = row_codes[31:24];
				2'd1:    glyph_code = row_codes[23:16];
				2'd2:    glyph_code = row_codes[15:8];
				default: glyph_code = row_codes[7:0];
			endcase
		end
	endfunction

endpackage

// ----- hdl/char_lcd_nibble_write_sequencer.sv -----
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)                          tuser          tlast
// s_*       in   value[7:0] row[8] column[14:9] digit[18:15] mode[1:0]      -
// m_*       out  nibble[3:0]                                 rs[0] error[1] last
//
// Each request expands to strobe beats, one per ready cycle: 2 for command, data
// and set-cursor requests, 12 for a big digit, 1 for a digit out of range.
// The beat counter over the held request sets that figure; a new request is taken
// in the same cycle the final beat of the previous one enters the output register.
// Reset clears the valid flags and the beat counter; payload is not reset.
// A stall on m_tready holds the output beat and backs up into the request register.

module char_lcd_nibble_write_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // value[7:0], row[8], column[14:9], digit[18:15]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // nibble[3:0]
	output logic [1:0]  m_tuser,   // rs[0], error[1]
	output logic        m_tlast
);
	import clnws_pkg::*;

	req_t       req_s1;
	logic       valid_s1;
	logic [3:0] idx_q;
	beat_t      beat;
	beat_t      out_q;
	logic       out_valid_q;
	logic       advance;
	logic       s_accept;
	req_t       req_in;

	// unpack the incoming beat
	assign req_in.mode   = mode_t'(s_tuser);
	assign req_in.value  = s_tdata[7:0];
	assign req_in.row    = s_tdata[8];
	assign req_in.column = s_tdata[14:9];
	assign req_in.digit  = s_tdata[18:15];

	clnws_beat u_beat (
		.req  (req_s1),
		.idx  (idx_q),
		.beat (beat)
	);

	// move one beat into the output register when it is empty or draining
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	// take the next request as soon as the held one sends its final beat
	assign s_tready = !valid_s1 || (advance && beat.last);
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= 4'd0;
		end else begin
			if (s_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance && beat.last) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				idx_q <= beat.last ? 4'd0 : idx_q + 4'd1;
			end
		end
	end

	// request payload: hold until the final beat goes out
	always_ff @(posedge clk) begin
		if (s_accept) begin
			req_s1 <= req_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= beat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'h0, out_q.nibble};
	assign m_tuser  = {out_q.error, out_q.rs};
	assign m_tlast  = out_q.last;

	// the beat counter never runs past the final beat of a big digit
	assert property (@(posedge clk) disable iff (!arst_n) idx_q <= DIGIT_LAST)
		else $error("beat counter out of range");

	// an error beat is always a final beat with an empty strobe
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast && m_tdata == 8'h00 && !m_tuser[0])
		else $error("error beat malformed");

	// an idle counter means no request is part way through
	assert property (@(posedge clk) disable iff (!arst_n) !valid_s1 |-> idx_q == 4'd0)
		else $error("beat counter not cleared between requests");

	// a final beat that leaves for the output frees the request register
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && beat.last && !s_tvalid |=> !valid_s1)
		else $error("request register not released after final beat");

endmodule

// ----- hdl/clnws_beat.sv -----
`timescale 1ns / 1ps

// Forms the strobe at a given beat index of one request.
module clnws_beat (
	input  clnws_pkg::req_t   req,
	input  logic [3:0]        idx,
	output clnws_pkg::beat_t  beat
);
	import clnws_pkg::*;

	logic [7:0] byte_val;
	logic       byte_rs;
	logic       is_err;
	logic [7:0] addr_row0;
	logic [7:0] addr_row1;

	assign addr_row0 = {ADDR_ROW0, req.column};
	assign addr_row1 = {ADDR_ROW1, req.column};
	assign is_err    = (req.mode == MODE_DIGIT) && (req.digit > DIGIT_MAX);

	always_comb begin
		byte_val = 8'h00;
		byte_rs  = 1'b0;
		unique case (req.mode)
			MODE_CMD: begin
				byte_val = req.value;
			end
			MODE_DATA: begin
				byte_val = req.value;
				byte_rs  = 1'b1;
			end
			MODE_CURSOR: begin
				byte_val = req.row ? addr_row1 : addr_row0;
			end
			default: begin
				// byte order: address row 0, two glyphs, address row 1, two glyphs
				case (idx[3:1])
					3'd0: byte_val = addr_row0;
					3'd1: begin byte_val = glyph_code(req.digit, 2'd0); byte_rs = 1'b1; end
					3'd2: begin byte_val = glyph_code(req.digit, 2'd1); byte_rs = 1'b1; end
					3'd3: byte_val = addr_row1;
					3'd4: begin byte_val = glyph_code(req.digit, 2'd2); byte_rs = 1'b1; end
					default: begin byte_val = glyph_code(req.digit, 2'd3); byte_rs = 1'b1; end
				endcase
			end
		endcase

		if (is_err) begin
			beat.rs     = 1'b0;
			beat.nibble = 4'h0;
			beat.last   = 1'b1;
			beat.error  = 1'b1;
		end else begin
			beat.rs     = byte_rs;
			beat.nibble = idx[0] ? byte_val[3:0] : byte_val[7:4];
			beat.last   = (req.mode == MODE_DIGIT) ? (idx == DIGIT_LAST) : (idx == BYTE_LAST);
			beat.error  = 1'b0;
		end
	end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import clnws_pkg::*;

	// Glyph codes of the big digits, digit 0 slot 0 in the top byte.
	localparam logic [319:0] GLYPH_ROM = {
		32'h01_02_4C_00, 32'h20_7C_20_7C, 32'h04_05_4C_5F, 32'h06_05_5F_00,
		32'h4C_00_20_03, 32'h07_04_5F_00, 32'h07_04_4C_00, 32'h06_02_20_03,
		32'h07_05_4C_00, 32'h07_05_20_03
	};
	localparam logic [7:0] CURSOR_ROW0 = 8'h80;
	localparam logic [7:0] CURSOR_ROW1 = 8'hC0;

	// Holds the strobes still owed by the block and checks each one that comes out.
	class strobe_scoreboard;
		beat_t       pending_strobes[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
		endfunction

		function int unsigned outstanding();
			return pending_strobes.size();
		endfunction

		function void push_byte(logic rs, logic [7:0] code, logic fin);
			beat_t hi;
			beat_t lo;
			hi = '{rs: rs, nibble: code[7:4], last: 1'b0, error: 1'b0};
			lo = '{rs: rs, nibble: code[3:0], last: fin, error: 1'b0};
			pending_strobes.push_back(hi);
			pending_strobes.push_back(lo);
		endfunction

		function logic [7:0] glyph(logic [3:0] d, int unsigned slot);
			int unsigned idx;
			idx = d * 4 + slot;
			return GLYPH_ROM[319 - 8 * idx -: 8];
		endfunction

		// Expand one accepted request into the strobes it causes.
		function void add_request(mode_t mode, logic [7:0] value, logic row,
				logic [5:0] column, logic [3:0] digit);
			beat_t fault;
			case (mode)
				MODE_CMD:    push_byte(1'b0, value, 1'b1);
				MODE_DATA:   push_byte(1'b1, value, 1'b1);
				MODE_CURSOR: push_byte(1'b0, (row ? CURSOR_ROW1 : CURSOR_ROW0) + column, 1'b1);
				default: begin
					if (digit > DIGIT_MAX) begin
						fault = '{rs: 1'b0, nibble: 4'd0, last: 1'b1, error: 1'b1};
						pending_strobes.push_back(fault);
					end else begin
						push_byte(1'b0, CURSOR_ROW0 + column, 1'b0);
						push_byte(1'b1, glyph(digit, 0), 1'b0);
						push_byte(1'b1, glyph(digit, 1), 1'b0);
						push_byte(1'b0, CURSOR_ROW1 + column, 1'b0);
						push_byte(1'b1, glyph(digit, 2), 1'b0);
						push_byte(1'b1, glyph(digit, 3), 1'b1);
					end
				end
			endcase
		endfunction

		function void check_strobe(logic rs, logic [3:0] nibble, logic last, logic error);
			beat_t want;
			if (pending_strobes.size() == 0) begin
				$error("unexpected beat: rs %0d nibble %h last %0d error %0d",
					rs, nibble, last, error);
				mismatches++;
				return;
			end
			want = pending_strobes.pop_front();
			if (rs !== want.rs) begin
				$error("rs: expected %0d, got %0d", want.rs, rs);
				mismatches++;
			end
			if (nibble !== want.nibble) begin
				$error("nibble: expected %h, got %h", want.nibble, nibble);
				mismatches++;
			end
			if (last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, last);
				mismatches++;
			end
			if (error !== want.error) begin
				$error("error: expected %0d, got %0d", want.error, error);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // value[7:0], row[8], column[14:9], digit[18:15]
	logic [1:0]  s_tuser;   // mode[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // nibble[3:0]
	logic [1:0]  m_tuser;   // rs[0], error[1]
	logic        m_tlast;

	strobe_scoreboard sb;
	bit               no_idle;

	char_lcd_nibble_write_sequencer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Mostly zero, often short, now and then a long hold.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Present one request from a falling edge and hold it until accepted.
	task automatic send_request(input mode_t mode, input logic [7:0] value, input logic row,
			input logic [5:0] column, input logic [3:0] digit);
		int unsigned gap;
		s_tvalid = 1'b1;
		s_tdata  = {5'd0, digit, column, row, value};
		s_tuser  = mode;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.add_request(mode, value, row, column, digit);
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			s_tdata  = 24'($urandom);
			s_tuser  = 2'($urandom);
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_random();
		mode_t       mode;
		logic [3:0]  digit;
		mode  = mode_t'($urandom_range(0, 3));
		digit = 4'($urandom_range(0, 15));
		// keep big digits mostly in range so the full glyph path gets the traffic
		if (mode == MODE_DIGIT && $urandom_range(0, 99) < 85)
			digit = 4'($urandom_range(0, 9));
		send_request(mode, 8'($urandom), 1'($urandom), 6'($urandom), digit);
	endtask

	// Receiver side: stall at random, short or long, except during a clean stretch.
	initial begin
		int unsigned stall_left;
		int unsigned r;
		m_tready   = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready = 1'b1;
				if (!no_idle) begin
					r = $urandom_range(0, 99);
					if (r < 20) begin
						m_tready   = 1'b0;
						stall_left = $urandom_range(0, 2);
					end else if (r < 23) begin
						m_tready   = 1'b0;
						stall_left = $urandom_range(10, 40);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_strobe(m_tuser[0], m_tdata[3:0], m_tlast, m_tuser[1]);
	end

	initial begin
		sb       = new();
		no_idle  = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: byte extremes, cursor corners, every glyph, out-of-range digits
		send_request(MODE_CMD,    8'h00, 1'b1, 6'h3F, 4'hF);
		send_request(MODE_CMD,    8'hFF, 1'b0, 6'h00, 4'h0);
		send_request(MODE_DATA,   8'h00, 1'b0, 6'h00, 4'h0);
		send_request(MODE_DATA,   8'hFF, 1'b1, 6'h3F, 4'hF);
		send_request(MODE_DATA,   8'hA5, 1'b0, 6'h15, 4'h6);
		send_request(MODE_CURSOR, 8'hFF, 1'b0, 6'h00, 4'hF);
		send_request(MODE_CURSOR, 8'h00, 1'b1, 6'h3F, 4'h0);
		send_request(MODE_CURSOR, 8'h5A, 1'b0, 6'h3F, 4'h9);
		send_request(MODE_CURSOR, 8'hC3, 1'b1, 6'h00, 4'hA);
		for (int d = 0; d <= 9; d++)
			send_request(MODE_DIGIT, 8'($urandom), 1'($urandom),
				(d % 2) ? 6'h3F : 6'h00, 4'(d));
		send_request(MODE_DIGIT, 8'h00, 1'b0, 6'h2A, 4'hA);
		send_request(MODE_DIGIT, 8'hFF, 1'b1, 6'h3F, 4'hF);

		// let the block drain completely before the random traffic
		s_tvalid = 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);

		for (int i = 0; i < 360; i++) begin
			if (i == 150)
				no_idle = 1'b1;
			if (i == 200)
				no_idle = 1'b0;
			send_random();
		end
		s_tvalid = 1'b0;

		while (sb.outstanding() != 0)
			@(negedge clk);
		repeat (30) @(posedge clk);
		if (sb.mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/clnws_pkg.sv
hdl/clnws_beat.sv
hdl/char_lcd_nibble_write_sequencer.sv
dv/testbench.sv
